// ===== rtl/ktr_pkg.sv =====
// ----------------------------------------------------------------------------
// ktr_pkg: shared types and constants for the typematic repeat unit
// Holds the key-of-interest map, register indexes and the beat structs
// passed between the repeat unit modules.
// ----------------------------------------------------------------------------
package ktr_pkg;

    // Scan code space and field widths
    localparam int SCAN_CODES = 256;
    localparam int CODE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int MS_W       = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MS_W;

    // Bit 7 of the raw event byte marks a key press
    localparam int PRESS_BIT = 7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

    // Register reset values
    localparam logic [MS_W-1:0] DELAY_RESET    = 12'd1000;
    localparam logic [MS_W-1:0] INTERVAL_RESET = 12'd400;

    // Item kinds
    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_POLL = 1'b1;

    // One bit per scan code; code 0 is never of interest
    localparam logic [SCAN_CODES-1:0] INTEREST_MAP = SCAN_CODES'(
        256'h00000000_000FAB80_01200000_30000000_00000000_018FFFBF_FFFFFFFF_FFFFFFFE);

    typedef struct packed {
        logic              action;
        logic [CODE_W-1:0] scan_code;
        logic [CODE_W-1:0] key_data;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic            enable;
        logic [MS_W-1:0] delay_ms;
        logic [MS_W-1:0] interval_ms;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] key_code;
        logic              pressed;
        logic              is_repeat;
    } t_result;

    // Look up a scan code in the key map
    function automatic logic of_interest(input logic [CODE_W-1:0] code);
        logic hit;
        hit = 1'b0;
        if ({1'b0, code} < (CODE_W + 1)'(SCAN_CODES)) begin
            hit = INTEREST_MAP[code];
        end
        return hit;
    endfunction

endpackage

// ===== rtl/ktr_cfg.sv =====
// ----------------------------------------------------------------------------
// ktr_cfg: configuration registers
// Holds enable, repeat delay and repeat interval; writes to unused indexes
// are dropped.
// ----------------------------------------------------------------------------
module ktr_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ktr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ktr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output ktr_pkg::t_cfg                    o_cfg
);
    import ktr_pkg::*;

    t_cfg r_cfg;

    // Capture a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b1;
            r_cfg.delay_ms    <= DELAY_RESET;
            r_cfg.interval_ms <= INTERVAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE:   r_cfg.enable      <= i_cfg_data[0];
                REG_DELAY:    r_cfg.delay_ms    <= i_cfg_data[MS_W-1:0];
                REG_INTERVAL: r_cfg.interval_ms <= i_cfg_data[MS_W-1:0];
                default:      r_cfg             <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/ktr_eval.sv =====
// ----------------------------------------------------------------------------
// ktr_eval: key tracking and repeat decision
// Holds the held key and its timestamps, decides the result of the item
// in the input register and updates the state when that item fires.
// ----------------------------------------------------------------------------
module ktr_eval (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  ktr_pkg::t_item   i_item,
    input  ktr_pkg::t_cfg    i_cfg,
    output ktr_pkg::t_result o_result
);
    import ktr_pkg::*;

    logic [CODE_W-1:0] r_held_key,    n_held_key;
    logic [TIME_W-1:0] r_press_time,  n_press_time;
    logic [TIME_W-1:0] r_repeat_time, n_repeat_time;

    logic              first_rpt;
    logic [TIME_W-1:0] ref_time;
    logic [TIME_W-1:0] elapsed;
    logic [MS_W-1:0]   limit;
    logic              due;
    logic              down;

    // Wrap-safe elapsed time against press or last repeat
    assign first_rpt = (r_repeat_time == r_press_time);
    assign ref_time  = first_rpt ? r_press_time : r_repeat_time;
    assign limit     = first_rpt ? i_cfg.delay_ms : i_cfg.interval_ms;
    assign elapsed   = i_item.now_ms - ref_time;
    assign due       = !elapsed[TIME_W-1] && (elapsed >= {{(TIME_W-MS_W){1'b0}}, limit});
    assign down      = i_item.key_data[PRESS_BIT];

    // Decide the result and the next state
    always_comb begin
        o_result      = '0;
        n_held_key    = r_held_key;
        n_press_time  = r_press_time;
        n_repeat_time = r_repeat_time;
        if (i_cfg.enable) begin
            if (i_item.action == ACT_KEY) begin
                if (of_interest(i_item.scan_code)) begin
                    o_result.valid    = 1'b1;
                    o_result.key_code = i_item.scan_code;
                    o_result.pressed  = down;
                    if (down) begin
                        n_held_key    = i_item.scan_code;
                        n_press_time  = i_item.now_ms;
                        n_repeat_time = i_item.now_ms;
                    end else if (i_item.scan_code == r_held_key) begin
                        n_held_key = '0;
                    end
                end
            end else if ((r_held_key != '0) && due) begin
                o_result.valid     = 1'b1;
                o_result.key_code  = r_held_key;
                o_result.pressed   = 1'b1;
                o_result.is_repeat = 1'b1;
                n_repeat_time      = i_item.now_ms;
            end
        end
    end

    // Commit state when the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_key    <= '0;
            r_press_time  <= '0;
            r_repeat_time <= '0;
        end else if (i_fire) begin
            r_held_key    <= n_held_key;
            r_press_time  <= n_press_time;
            r_repeat_time <= n_repeat_time;
        end
    end

endmodule

// ===== rtl/key_typematic_repeat_unit.sv =====
// ----------------------------------------------------------------------------
// key_typematic_repeat_unit: keyboard auto-repeat generator
// Echoes key events for mapped scan codes and emits repeats of the held
// key on poll beats after the configured delay and interval.
// ----------------------------------------------------------------------------
// Each beat passes through the input register and then the result register,
// where it is held while the output is stalled. Its result is loaded into the
// result register when the beat fires from the input register. A new beat is
// accepted every cycle while the output is not stalled.
// The rate is set by the combinational decision between the two registers,
// whose longest path is the 32-bit wrap-safe subtract and compare.
// Key beats for unmapped codes, disabled beats and polls that are not due
// give no output beat. Write configuration only while no beat is in flight.
module key_typematic_repeat_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_action,
    input  logic [ktr_pkg::CODE_W-1:0]     i_scan_code,
    input  logic [ktr_pkg::CODE_W-1:0]     i_key_data,
    input  logic [ktr_pkg::TIME_W-1:0]     i_now_ms,
    // Output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ktr_pkg::CODE_W-1:0]     o_key_code,
    output logic                           o_pressed,
    output logic                           o_is_repeat,
    // Configuration
    input  logic                           i_cfg_we,
    input  logic [ktr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ktr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ktr_pkg::*;

    t_cfg    cfg;
    t_result result;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;
    logic    fire;
    logic    in_accept;

    // Handshake: the result register frees when empty or taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    ktr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ktr_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register: load a beat, drop it once it fires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.action    <= i_action;
            r_item.scan_code <= i_scan_code;
            r_item.key_data  <= i_key_data;
            r_item.now_ms    <= i_now_ms;
        end
    end

    // Result register: hold while stalled, refill from the decision
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && out_free) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_code  = r_out.key_code;
    assign o_pressed   = r_out.pressed;
    assign o_is_repeat = r_out.is_repeat;

    // Checks
    a_repeat_pressed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_repeat |-> o_pressed)
        else $error("repeat beat without pressed");

    a_repeat_key : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_repeat |-> o_key_code != '0)
        else $error("repeat beat reports no key");

    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall && r_in_valid)
        else $error("input stalled while pipeline can advance");

    a_disabled_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !cfg.enable |=> !o_out_valid)
        else $error("output beat while disabled");

endmodule

// ===== test/tb_key_typematic_repeat_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_typematic_repeat_unit: self-checking bench for the auto-repeat unit
// Drives key and poll beats, predicts key echoes and typematic repeats with
// a behavioral model of the held-key timer, and checks every output beat in
// order. Covers map holes, wrap-safe timing, timing extremes, the disable
// switch and long random key/poll sessions under sender gaps and stalls.
// ----------------------------------------------------------------------------
module tb_key_typematic_repeat_unit;
    import ktr_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BEATS   = 440;
    localparam int DRAIN_EVERY   = 150;

    // Keys of interest, one bit per scan code
    localparam logic [255:0] KEY_MAP = {
        32'h0000_0000, 32'h000F_AB80, 32'h0120_0000, 32'h3000_0000,
        32'h0000_0000, 32'h018F_FFBF, 32'hFFFF_FFFF, 32'hFFFF_FFFE};

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              pressed;
        logic              is_repeat;
    } t_key_event;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic                  i_action    = ACT_KEY;
    logic [CODE_W-1:0]     i_scan_code = '0;
    logic [CODE_W-1:0]     i_key_data  = '0;
    logic [TIME_W-1:0]     i_now_ms    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [CODE_W-1:0]     o_key_code;
    logic                  o_pressed;
    logic                  o_is_repeat;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = REG_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Predicted unit state and register copy
    logic              cfg_enable   = 1'b1;
    logic [MS_W-1:0]   cfg_delay    = DELAY_RESET;
    logic [MS_W-1:0]   cfg_interval = INTERVAL_RESET;
    logic [CODE_W-1:0] held_code    = '0;
    logic [TIME_W-1:0] press_ms     = '0;
    logic [TIME_W-1:0] last_rep_ms  = '0;

    t_key_event pending_events[$];
    t_key_event seen_exp;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int n_errors     = 0;
    int n_beats      = 0;
    int n_echoes     = 0;
    int n_repeats    = 0;
    int n_checked    = 0;

    logic [TIME_W-1:0] tick_ms = '0;

    key_typematic_repeat_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_scan_code (i_scan_code),
        .i_key_data  (i_key_data),
        .i_now_ms    (i_now_ms),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_key_code  (o_key_code),
        .o_pressed   (o_pressed),
        .o_is_repeat (o_is_repeat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Random output stall, changed on the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        n_errors++;
    endtask

    function automatic logic key_mapped(input logic [CODE_W-1:0] code);
        return KEY_MAP[code];
    endfunction

    function automatic logic [CODE_W-1:0] pick_mapped_key();
        logic [CODE_W-1:0] code;
        do begin
            code = CODE_W'($urandom_range(255));
        end while (!key_mapped(code));
        return code;
    endfunction

    // Advance the held-key timer for one accepted beat
    task automatic predict_typematic(input logic act, input logic [CODE_W-1:0] code,
                                     input logic [CODE_W-1:0] data,
                                     input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] ref_ms;
        logic [TIME_W-1:0] elapsed;
        logic [MS_W-1:0]   limit;
        t_key_event        ev;
        if (!cfg_enable) return;
        if (act == ACT_KEY) begin
            if (!key_mapped(code)) return;
            if (data[PRESS_BIT]) begin
                held_code   = code;
                press_ms    = now;
                last_rep_ms = now;
            end else if (code == held_code) begin
                held_code = '0;
            end
            ev.key_code  = code;
            ev.pressed   = data[PRESS_BIT];
            ev.is_repeat = 1'b0;
            pending_events.push_back(ev);
            n_echoes++;
            return;
        end
        if (held_code == '0) return;
        // First repeat counts from the press, later ones from the last repeat
        if (last_rep_ms == press_ms) begin
            ref_ms = press_ms;
            limit  = cfg_delay;
        end else begin
            ref_ms = last_rep_ms;
            limit  = cfg_interval;
        end
        elapsed = now - ref_ms;
        if (elapsed[TIME_W-1] || elapsed < TIME_W'(limit)) return;
        last_rep_ms  = now;
        ev.key_code  = held_code;
        ev.pressed   = 1'b1;
        ev.is_repeat = 1'b1;
        pending_events.push_back(ev);
        n_repeats++;
    endtask

    // Send one beat; entered and left just after a rising edge
    task automatic send_beat(input logic act, input logic [CODE_W-1:0] code,
                             input logic [CODE_W-1:0] data, input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_scan_code <= code;
        i_key_data  <= data;
        i_now_ms    <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_beats++;
        predict_typematic(act, code, data, now);
    endtask

    // Hold the input, drain all results, then let the pipeline settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_ENABLE:   cfg_enable   = data[0];
            REG_DELAY:    cfg_delay    = data;
            REG_INTERVAL: cfg_interval = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [MS_W-1:0] delay, input logic [MS_W-1:0] interval);
        wait_idle();
        write_reg(REG_DELAY, delay);
        write_reg(REG_INTERVAL, interval);
    endtask

    // Map holes, release of a non-held key and repeat timing at reset values
    task automatic test_key_echo();
        send_beat(ACT_KEY, 8'h00, 8'h80, 32'd10);
        send_beat(ACT_KEY, 8'hFF, 8'hFF, 32'd20);
        send_beat(ACT_KEY, 8'h46, 8'h80, 32'd30);
        send_beat(ACT_KEY, 8'h01, 8'h7F, 32'd40);
        send_beat(ACT_KEY, 8'hD3, 8'h80, 32'd1000);
        send_beat(ACT_POLL, 8'hFF, 8'hFF, 32'd1999);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'd2000);
        send_beat(ACT_POLL, 8'h12, 8'h34, 32'd2399);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'd2400);
        send_beat(ACT_KEY, 8'h1E, 8'hC5, 32'd2500);
        send_beat(ACT_KEY, 8'hD3, 8'h00, 32'd2600);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'd3500);
        send_beat(ACT_KEY, 8'h1E, 8'h00, 32'd3600);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'd9000);
        wait_idle();
    endtask

    // Press just before the counter wraps; reference in the future
    task automatic test_time_wrap();
        send_beat(ACT_KEY, 8'h9D, 8'h80, 32'hFFFF_FE00);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'h0000_01E7);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'h0000_01E8);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'h0000_01E7);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'h8000_01E8);
        wait_idle();
    endtask

    // Zero delay stays in first-repeat mode; full-scale delay and interval
    task automatic test_timing_extremes();
        set_timing('0, '0);
        send_beat(ACT_KEY, 8'h39, 8'h80, 32'h0000_1234);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'h0000_1234);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'h0000_1234);
        set_timing('1, '1);
        send_beat(ACT_KEY, 8'hB8, 8'h80, 32'd0);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'd4094);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'd4095);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'd8190);
        wait_idle();
    endtask

    // Disabled beats give nothing and leave the held key alone
    task automatic test_disable();
        write_reg(REG_ENABLE, '0);
        send_beat(ACT_KEY, 8'h20, 8'h80, 32'd9000);
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'd20000);
        wait_idle();
        write_reg(REG_ENABLE, CFG_DATA_W'(1));
        send_beat(ACT_POLL, 8'h00, 8'h00, 32'd12285);
        wait_idle();
    endtask

    // Press/poll/release sessions with random content, plus noise
    task automatic test_random_traffic(input int gap_pct, input int stl_pct,
                                       input logic [MS_W-1:0] delay,
                                       input logic [MS_W-1:0] interval);
        int                unsigned r;
        int                unsigned span;
        logic [CODE_W-1:0] code;
        set_timing(delay, interval);
        send_gap_pct = gap_pct;
        stall_pct    = stl_pct;
        span = ((delay > interval) ? delay : interval) / 3 + 2;
        for (int i = 0; i < PHASE_BEATS; i++) begin
            r = $urandom_range(99);
            if (held_code == '0 && r >= 40 && $urandom_range(1) == 1) r = 12;
            if (r < 8) begin
                send_beat(logic'($urandom_range(1)), CODE_W'($urandom),
                          CODE_W'($urandom), $urandom);
            end else if (r < 22) begin
                tick_ms += TIME_W'($urandom_range(0, 20));
                send_beat(ACT_KEY, pick_mapped_key(),
                          {1'b1, 7'($urandom)}, tick_ms);
            end else if (r < 30) begin
                code = (held_code != '0 && $urandom_range(3) != 0) ? held_code
                                                                   : pick_mapped_key();
                send_beat(ACT_KEY, code, {1'b0, 7'($urandom)}, tick_ms);
            end else if (r < 35) begin
                send_beat(ACT_KEY, CODE_W'($urandom), CODE_W'($urandom), tick_ms);
            end else if (r < 37) begin
                tick_ms = $urandom;
                send_beat(ACT_POLL, CODE_W'($urandom), CODE_W'($urandom), tick_ms);
            end else if (r < 40) begin
                send_beat(ACT_POLL, CODE_W'($urandom), CODE_W'($urandom),
                          tick_ms - TIME_W'($urandom_range(1, 50)));
            end else begin
                tick_ms += TIME_W'($urandom_range(0, span));
                send_beat(ACT_POLL, CODE_W'($urandom), CODE_W'($urandom), tick_ms);
            end
            // Hold off the sender until all results are back
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1) wait_idle();
        end
        wait_idle();
    endtask

    // Compare each output beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected beat code %02h pressed %0b repeat %0b",
                                          o_key_code, o_pressed, o_is_repeat));
            end else begin
                seen_exp = pending_events.pop_front();
                n_checked++;
                if (o_key_code !== seen_exp.key_code)
                    report_mismatch($sformatf("key_code %02h, want %02h",
                                              o_key_code, seen_exp.key_code));
                if (o_pressed !== seen_exp.pressed)
                    report_mismatch($sformatf("pressed %0b, want %0b",
                                              o_pressed, seen_exp.pressed));
                if (o_is_repeat !== seen_exp.is_repeat)
                    report_mismatch($sformatf("is_repeat %0b, want %0b",
                                              o_is_repeat, seen_exp.is_repeat));
            end
        end
    end

    // Run the tests in turn
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_key_echo();
        test_time_wrap();
        test_timing_extremes();
        test_disable();
        test_random_traffic(0, 0, MS_W'($urandom_range(0, 40)), MS_W'($urandom_range(0, 40)));
        test_random_traffic(50, 0, '0, '0);
        test_random_traffic(0, 50, '1, '1);
        test_random_traffic(29, 29, MS_W'($urandom), MS_W'($urandom));

        if (pending_events.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_events.size()));
        $display("Run sent %0d beats; checked %0d results (%0d echoes, %0d repeats)",
                 n_beats, n_checked, n_echoes, n_repeats);
        $display("Timing swept from 0 to 4095 ms with enable toggled and random gaps/stalls");
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ktr_pkg.sv
rtl/ktr_cfg.sv
rtl/ktr_eval.sv
rtl/key_typematic_repeat_unit.sv
test/tb_key_typematic_repeat_unit.sv
